>>> rtl/core/lfps_pkg.sv
// Shared types, constants and helpers for the line-follow PD steering unit.
// No dependencies.
package lfps_pkg;

    localparam int PROD_W = 59;
    localparam int ERR_W  = 48;
    localparam int CORR_W = 52;
    localparam int NORM_W = 17;

    localparam logic [16:0] ONE_Q16     = 17'd65536;
    localparam logic [7:0]  STOP_LINES  = 8'd2;
    localparam logic [25:0] WHITE_LIMIT = 26'd65536;

    localparam logic [1:0] STOP_NONE  = 2'd0;
    localparam logic [1:0] STOP_LINE  = 2'd1;
    localparam logic [1:0] STOP_WHITE = 2'd2;

    localparam logic [2:0] REG_CAL_MIN_A   = 3'd0;
    localparam logic [2:0] REG_CAL_MIN_B   = 3'd1;
    localparam logic [2:0] REG_CAL_MAX_A   = 3'd2;
    localparam logic [2:0] REG_CAL_MAX_B   = 3'd3;
    localparam logic [2:0] REG_PROP_GAIN   = 3'd4;
    localparam logic [2:0] REG_DERIV_GAIN  = 3'd5;
    localparam logic [2:0] REG_SPEED_SCALE = 3'd6;

    localparam logic [5:0] NORM_STEPS  = 6'd17;
    localparam logic [5:0] DERIV_STEPS = 6'd33;

    typedef struct packed {
        logic        start;
        logic [31:0] rem_init;
        logic [32:0] dividend;
        logic [31:0] divisor;
        logic [5:0]  steps;
    } div_req_t;

    function automatic logic [15:0] sat_level(input logic signed [CORR_W-1:0] lvl);
        logic signed [CORR_W-1:0] v;
        logic [15:0] r;
        begin
            v = lvl >>> 2;
            if (v > $signed(52'sd32767))
                r = 16'h7FFF;
            else if (v < -$signed(52'sd32768))
                r = 16'h8000;
            else
                r = v[15:0];
            return r;
        end
    endfunction

endpackage

>>> rtl/core/lfps_div.sv
// Shift-subtract divider, one quotient bit per cycle.
// Depends on lfps_pkg for the request struct.
module lfps_div (
    input  logic              clk,
    input  logic              rst_n,
    input  lfps_pkg::div_req_t req,
    output logic              done,
    output logic [32:0]       quot
);
    import lfps_pkg::*;

    logic        busy_reg;
    logic        done_reg;
    logic [5:0]  cnt_reg;
    logic [31:0] rem_reg;
    logic [32:0] sh_reg;
    logic [32:0] q_reg;
    logic [31:0] d_reg;

    logic [32:0] trial;
    logic [32:0] diff;
    logic        ge;

    always_comb
    begin
        trial = {rem_reg, sh_reg[32]};
        ge    = trial >= {1'b0, d_reg};
        diff  = trial - {1'b0, d_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= req.steps;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= req.rem_init;
            sh_reg  <= req.dividend;
            d_reg   <= req.divisor;
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[31:0] : trial[31:0];
            sh_reg  <= {sh_reg[31:0], 1'b0};
            q_reg   <= {q_reg[31:0], ge};
        end
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule

>>> rtl/core/lfps_mul.sv
// Registered signed multiplier shared by the gain and derivative terms.
// Depends on lfps_pkg for the product width.
module lfps_mul (
    input  logic                               clk,
    input  logic signed [33:0]                 a,
    input  logic signed [24:0]                 b,
    output logic signed [lfps_pkg::PROD_W-1:0] p
);
    import lfps_pkg::*;

    logic signed [PROD_W-1:0] p_reg;

    always_ff @(posedge clk)
    begin
        p_reg <= a * b;
    end

    assign p = p_reg;

endmodule

>>> rtl/core/line_follow_pd_steering_unit.sv
// Top level of the line-follow PD steering unit: config, sequencer, datapath.
// Depends on lfps_pkg, lfps_div and lfps_mul.
//
//  channel | handshake          | payload
//  in      | in_valid/in_stall  | six raw readings, tick_now, line_count
//  out     | out_valid/out_stall| left/right drive, motor_scale, stop_reason, zero_interval
//  cfg     | cfg_we             | cfg_index, cfg_data
//
// A full beat runs six normalizing divisions, the error products and error step,
// a derivative division and the finishing steps, in that order. Equal or inverted
// bounds skip a reading's division, and a zero interval skips the derivative division.
// A line-count stop skips all of these steps. Reset clears state and loads defaults.
// in_stall is high while a beat is in work; a result waits in the output
// register under out_stall while the next beat is taken.
module line_follow_pd_steering_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [15:0] raw_left_inner,
    input  logic [15:0] raw_left_mid,
    input  logic [15:0] raw_left_outer,
    input  logic [15:0] raw_right_inner,
    input  logic [15:0] raw_right_mid,
    input  logic [15:0] raw_right_outer,
    input  logic [31:0] tick_now,
    input  logic [7:0]  line_count,
    output logic        out_valid,
    input  logic        out_stall,
    output logic signed [15:0] left_drive,
    output logic signed [15:0] right_drive,
    output logic [15:0] motor_scale,
    output logic [1:0]  stop_reason,
    output logic        zero_interval
);
    import lfps_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_NORM, S_NWAIT, S_M1, S_M2, S_M3, S_ERR, S_DIFF, S_DWAIT,
        S_K1, S_K2, S_K3, S_DONE
    } state_t;

    state_t state_reg;

    logic [63:0] cal_min_a_reg, cal_max_a_reg;
    logic [31:0] cal_min_b_reg, cal_max_b_reg;
    logic [23:0] prop_gain_reg;
    logic [31:0] deriv_gain_reg;
    logic [15:0] speed_scale_reg;

    logic [31:0]           last_tick_reg;
    logic signed [ERR_W-1:0] last_error_reg;

    logic [15:0] raw_reg [6];
    logic [31:0] tick_reg;
    logic [NORM_W-1:0] n_reg [6];
    logic [2:0]  idx_reg;
    logic signed [PROD_W-1:0] m1_reg, m2_reg, t1_reg;
    logic signed [ERR_W-1:0] e_reg;
    logic [31:0] dt_reg;
    logic        neg_reg;
    logic [32:0] q_reg;

    logic [15:0] res_left_reg, res_right_reg, res_scale_reg;
    logic [1:0]  res_stop_reg;
    logic        res_zero_reg;

    logic        out_valid_reg;
    logic [15:0] left_reg, right_reg, scale_reg;
    logic [1:0]  stop_reg;
    logic        zero_reg;

    logic [15:0] lo_w [6];
    logic [15:0] hi_w [6];
    logic [15:0] sel_raw, sel_lo, sel_hi, clamped, span, xval;
    logic        norm_direct;
    logic [NORM_W-1:0] norm_val;

    div_req_t    div_req;
    logic        div_done;
    logic [32:0] div_quot;

    logic signed [33:0] mul_a;
    logic signed [24:0] mul_b;
    logic signed [PROD_W-1:0] mul_p;

    logic signed [PROD_W-1:0] sum_main, sum_sharp;
    logic signed [ERR_W-1:0]  e_main, e_sharp;
    logic [18:0] white_sum;
    logic [25:0] white_x100;
    logic        all_white;
    logic        mid_black;
    logic signed [ERR_W:0] diff_w;
    logic [32:0] mag_w;
    logic signed [PROD_W-1:0] term_w;
    logic signed [CORR_W-1:0] corr_w, left_w, right_w;

    logic in_acc, out_acc;

    assign in_acc  = in_valid && !in_stall;
    assign out_acc = out_valid_reg && !out_stall;
    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            lo_w[i] = cal_min_a_reg[16*i +: 16];
            hi_w[i] = cal_max_a_reg[16*i +: 16];
        end
        for (int i = 0; i < 2; i++)
        begin
            lo_w[4+i] = cal_min_b_reg[16*i +: 16];
            hi_w[4+i] = cal_max_b_reg[16*i +: 16];
        end
        sel_raw = raw_reg[idx_reg];
        sel_lo  = lo_w[idx_reg];
        sel_hi  = hi_w[idx_reg];
        if (sel_raw < sel_lo)
            clamped = sel_lo;
        else if (sel_raw > sel_hi)
            clamped = sel_hi;
        else
            clamped = sel_raw;
        span = sel_hi - sel_lo;
        xval = clamped - sel_lo;
        norm_direct = (sel_lo >= sel_hi);
        if (sel_lo > sel_hi)
            norm_val = (sel_raw < sel_lo) ? '0 : ONE_Q16;
        else
            norm_val = '0;
    end

    always_comb
    begin
        white_sum  = 19'(n_reg[0]) + 19'(n_reg[2]) + 19'(n_reg[3]) + 19'(n_reg[5]);
        white_x100 = 26'(white_sum) * 26'd100;
        all_white  = white_x100 < WHITE_LIMIT;
        mid_black  = (n_reg[1] != '0) || (n_reg[4] != '0);
        sum_main   = m1_reg + (m2_reg <<< 6) + (m2_reg <<< 5) + (m2_reg <<< 2);
        sum_sharp  = (mul_p <<< 6) + (mul_p <<< 5) + (mul_p <<< 2);
        e_main     = ERR_W'($signed(sum_main[PROD_W-1:16]));
        e_sharp    = ERR_W'($signed(sum_sharp[PROD_W-1:16]));
        diff_w     = {e_reg[ERR_W-1], e_reg} - {last_error_reg[ERR_W-1], last_error_reg};
        mag_w      = diff_w[ERR_W] ? 33'(-diff_w) : diff_w[32:0];
        term_w     = t1_reg + (mul_p >>> 16);
        corr_w     = neg_reg ? (CORR_W'(e_reg) - CORR_W'(term_w))
                             : (CORR_W'(e_reg) + CORR_W'(term_w));
        if (corr_w <= 0)
        begin
            left_w  = CORR_W'(ONE_Q16) + corr_w;
            right_w = CORR_W'(ONE_Q16);
        end
        else
        begin
            left_w  = CORR_W'(ONE_Q16);
            right_w = CORR_W'(ONE_Q16) - corr_w;
        end
    end

    always_comb
    begin
        div_req = '0;
        if (state_reg == S_NORM && !norm_direct)
        begin
            div_req.start    = 1'b1;
            div_req.rem_init = {17'd0, xval[15:1]};
            div_req.dividend = {xval[0], 32'd0};
            div_req.divisor  = {16'd0, span};
            div_req.steps    = NORM_STEPS;
        end
        else if (state_reg == S_DIFF && dt_reg != '0)
        begin
            div_req.start    = 1'b1;
            div_req.rem_init = '0;
            div_req.dividend = mag_w;
            div_req.divisor  = dt_reg;
            div_req.steps    = DERIV_STEPS;
        end
    end

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_M1:
            begin
                mul_a = 34'($signed({1'b0, n_reg[3]}) - $signed({1'b0, n_reg[0]}));
                mul_b = $signed({1'b0, prop_gain_reg});
            end
            S_M2:
            begin
                mul_a = 34'($signed({1'b0, n_reg[5]}) - $signed({1'b0, n_reg[2]}));
                mul_b = $signed({1'b0, prop_gain_reg});
            end
            S_M3:
            begin
                mul_a = 34'($signed({1'b0, n_reg[4]}) - $signed({1'b0, n_reg[1]}));
                mul_b = $signed({1'b0, prop_gain_reg});
            end
            S_K1:
            begin
                mul_a = $signed({1'b0, q_reg});
                mul_b = $signed({9'd0, deriv_gain_reg[31:16]});
            end
            S_K2:
            begin
                mul_a = $signed({1'b0, q_reg});
                mul_b = $signed({9'd0, deriv_gain_reg[15:0]});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    lfps_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .done  (div_done),
        .quot  (div_quot)
    );

    lfps_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_min_a_reg   <= '0;
            cal_min_b_reg   <= '0;
            cal_max_a_reg   <= '1;
            cal_max_b_reg   <= '1;
            prop_gain_reg   <= 24'd65536;
            deriv_gain_reg  <= '0;
            speed_scale_reg <= 16'd32768;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_CAL_MIN_A:   cal_min_a_reg   <= cfg_data;
                REG_CAL_MIN_B:   cal_min_b_reg   <= cfg_data[31:0];
                REG_CAL_MAX_A:   cal_max_a_reg   <= cfg_data;
                REG_CAL_MAX_B:   cal_max_b_reg   <= cfg_data[31:0];
                REG_PROP_GAIN:   prop_gain_reg   <= cfg_data[23:0];
                REG_DERIV_GAIN:  deriv_gain_reg  <= cfg_data[31:0];
                REG_SPEED_SCALE: speed_scale_reg <= cfg_data[15:0];
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            last_tick_reg  <= '0;
            last_error_reg <= '0;
            out_valid_reg  <= 1'b0;
            idx_reg        <= '0;
        end
        else
        begin
            if (out_acc && state_reg != S_DONE)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_acc)
                    begin
                        raw_reg[0]    <= raw_left_inner;
                        raw_reg[1]    <= raw_left_mid;
                        raw_reg[2]    <= raw_left_outer;
                        raw_reg[3]    <= raw_right_inner;
                        raw_reg[4]    <= raw_right_mid;
                        raw_reg[5]    <= raw_right_outer;
                        tick_reg      <= tick_now;
                        idx_reg       <= '0;
                        res_left_reg  <= '0;
                        res_right_reg <= '0;
                        res_scale_reg <= '0;
                        res_zero_reg  <= 1'b0;
                        if (line_count >= STOP_LINES)
                        begin
                            res_stop_reg <= STOP_LINE;
                            state_reg    <= S_DONE;
                        end
                        else
                        begin
                            res_stop_reg <= STOP_NONE;
                            state_reg    <= S_NORM;
                        end
                    end
                end
                S_NORM:
                begin
                    if (norm_direct)
                    begin
                        n_reg[idx_reg] <= norm_val;
                        idx_reg        <= idx_reg + 3'd1;
                        state_reg      <= (idx_reg == 3'd5) ? S_M1 : S_NORM;
                    end
                    else
                        state_reg <= S_NWAIT;
                end
                S_NWAIT:
                begin
                    if (div_done)
                    begin
                        n_reg[idx_reg] <= div_quot[NORM_W-1:0];
                        idx_reg        <= idx_reg + 3'd1;
                        state_reg      <= (idx_reg == 3'd5) ? S_M1 : S_NORM;
                    end
                end
                S_M1:
                    state_reg <= S_M2;
                S_M2:
                begin
                    m1_reg    <= mul_p;
                    state_reg <= S_M3;
                end
                S_M3:
                begin
                    m2_reg    <= mul_p;
                    state_reg <= S_ERR;
                end
                S_ERR:
                begin
                    if (all_white && !mid_black)
                    begin
                        res_stop_reg <= STOP_WHITE;
                        state_reg    <= S_DONE;
                    end
                    else
                    begin
                        e_reg     <= all_white ? e_sharp : e_main;
                        dt_reg    <= tick_reg - last_tick_reg;
                        state_reg <= S_DIFF;
                    end
                end
                S_DIFF:
                begin
                    last_tick_reg  <= tick_reg;
                    last_error_reg <= e_reg;
                    neg_reg        <= diff_w[ERR_W];
                    if (dt_reg == '0)
                    begin
                        res_zero_reg <= 1'b1;
                        q_reg        <= '0;
                        state_reg    <= S_K1;
                    end
                    else
                        state_reg <= S_DWAIT;
                end
                S_DWAIT:
                begin
                    if (div_done)
                    begin
                        q_reg     <= div_quot;
                        state_reg <= S_K1;
                    end
                end
                S_K1:
                    state_reg <= S_K2;
                S_K2:
                begin
                    t1_reg    <= mul_p;
                    state_reg <= S_K3;
                end
                S_K3:
                begin
                    res_left_reg  <= sat_level(left_w);
                    res_right_reg <= sat_level(right_w);
                    res_scale_reg <= speed_scale_reg;
                    state_reg     <= S_DONE;
                end
                S_DONE:
                begin
                    if (!out_valid_reg || out_acc)
                    begin
                        left_reg      <= res_left_reg;
                        right_reg     <= res_right_reg;
                        scale_reg     <= res_scale_reg;
                        stop_reg      <= res_stop_reg;
                        zero_reg      <= res_zero_reg;
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign out_valid     = out_valid_reg;
    assign left_drive    = left_reg;
    assign right_drive   = right_reg;
    assign motor_scale   = scale_reg;
    assign stop_reason   = stop_reg;
    assign zero_interval = zero_reg;

endmodule

>>> tb/testbench.sv
// Testbench for line_follow_pd_steering_unit: random and directed sensor frames,
// register changes between phases, a PD steering predictor and a scoreboard.
// Depends on lfps_pkg and the RTL of the steering unit.
`timescale 1ns / 1ps

class steer_scoreboard;
    logic [63:0] min_a, max_a;
    logic [31:0] min_b, max_b, kp, kd, spd;
    logic [31:0] prev_tick;
    longint      prev_err;
    logic [15:0] exp_left[$], exp_right[$], exp_scale[$];
    logic [1:0]  exp_stop[$];
    logic        exp_zero[$];
    int          errors;

    function new();
        min_a = 64'd0; min_b = 32'd0;
        max_a = '1; max_b = '1;
        kp = 32'd65536; kd = 32'd0; spd = 32'd32768;
        prev_tick = 32'd0; prev_err = 0;
        errors = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [63:0] v);
        case (idx)
            lfps_pkg::REG_CAL_MIN_A:   min_a = v;
            lfps_pkg::REG_CAL_MIN_B:   min_b = v[31:0];
            lfps_pkg::REG_CAL_MAX_A:   max_a = v;
            lfps_pkg::REG_CAL_MAX_B:   max_b = v[31:0];
            lfps_pkg::REG_PROP_GAIN:   kp = {8'd0, v[23:0]};
            lfps_pkg::REG_DERIV_GAIN:  kd = v[31:0];
            lfps_pkg::REG_SPEED_SCALE: spd = {16'd0, v[15:0]};
            default: ;
        endcase
    endfunction

    function longint normalize(longint r, longint lo, longint hi);
        if (lo > hi) return (r < lo) ? 0 : 65536;
        if (lo == hi) return 0;
        if (r < lo) r = lo;
        else if (r > hi) r = hi;
        return ((r - lo) * 65536) / (hi - lo);
    endfunction

    function longint floor_div(longint x, longint d);
        if (x >= 0) return x / d;
        return -((-x + d - 1) / d);
    endfunction

    function logic [15:0] level(longint q);
        longint v;
        v = floor_div(q, 4);
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return v[15:0];
    endfunction

    function void note_frame(logic [15:0] raw[6], logic [31:0] now, logic [7:0] lines);
        longint n[6], lo, hi, e, deriv, corr, lft, rgt, g;
        logic [63:0] mag, term;
        logic [31:0] dt;
        logic zero;
        deriv = 0;
        zero = 1'b0;
        g = kp;
        for (int i = 0; i < 6; i++)
        begin
            lo = (i < 4) ? min_a[16*i +: 16] : min_b[16*(i-4) +: 16];
            hi = (i < 4) ? max_a[16*i +: 16] : max_b[16*(i-4) +: 16];
            n[i] = normalize(raw[i], lo, hi);
        end
        if (lines >= lfps_pkg::STOP_LINES)
        begin
            push(16'd0, 16'd0, 16'd0, lfps_pkg::STOP_LINE, 1'b0);
            return;
        end
        e = floor_div(g * (n[3] - n[0]) + 100 * g * (n[5] - n[2]), 65536);
        if ((n[0] + n[3] + n[2] + n[5]) * 100 < 65536)
        begin
            if (n[1] + n[4] > 0)
                e = floor_div(100 * g * (n[4] - n[1]), 65536);
            else
            begin
                push(16'd0, 16'd0, 16'd0, lfps_pkg::STOP_WHITE, 1'b0);
                return;
            end
        end
        dt = now - prev_tick;
        if (dt == 0) zero = 1'b1;
        else deriv = (e - prev_err) / longint'({32'd0, dt});
        prev_tick = now;
        prev_err = e;
        mag = (deriv < 0) ? -deriv : deriv;
        term = mag * kd[31:16] + ((mag * kd[15:0]) >> 16);
        corr = e + ((deriv < 0) ? -longint'(term) : longint'(term));
        if (corr <= 0)
        begin
            lft = 65536 + corr; rgt = 65536;
        end
        else
        begin
            lft = 65536; rgt = 65536 - corr;
        end
        push(level(lft), level(rgt), spd[15:0], lfps_pkg::STOP_NONE, zero);
    endfunction

    function void push(logic [15:0] l, logic [15:0] r, logic [15:0] s, logic [1:0] st,
                       logic z);
        exp_left.push_back(l); exp_right.push_back(r); exp_scale.push_back(s);
        exp_stop.push_back(st); exp_zero.push_back(z);
    endfunction

    function void check_result(logic [15:0] l, logic [15:0] r, logic [15:0] s,
                               logic [1:0] st, logic z);
        if (exp_left.size() == 0)
        begin
            $error("result beat with nothing expected");
            errors++;
            return;
        end
        if (exp_left[0] !== l)
        begin
            $error("left_drive expected %h actual %h", exp_left[0], l); errors++;
        end
        if (exp_right[0] !== r)
        begin
            $error("right_drive expected %h actual %h", exp_right[0], r); errors++;
        end
        if (exp_scale[0] !== s)
        begin
            $error("motor_scale expected %h actual %h", exp_scale[0], s); errors++;
        end
        if (exp_stop[0] !== st)
        begin
            $error("stop_reason expected %0d actual %0d", exp_stop[0], st); errors++;
        end
        if (exp_zero[0] !== z)
        begin
            $error("zero_interval expected %0d actual %0d", exp_zero[0], z); errors++;
        end
        void'(exp_left.pop_front()); void'(exp_right.pop_front());
        void'(exp_scale.pop_front()); void'(exp_stop.pop_front());
        void'(exp_zero.pop_front());
    endfunction
endclass

module testbench;
    logic        clk, rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [63:0] cfg_data;
    logic        in_valid, in_stall, out_valid, out_stall;
    logic [15:0] raw_left_inner, raw_left_mid, raw_left_outer;
    logic [15:0] raw_right_inner, raw_right_mid, raw_right_outer;
    logic [31:0] tick_now;
    logic [7:0]  line_count;
    logic signed [15:0] left_drive, right_drive;
    logic [15:0] motor_scale;
    logic [1:0]  stop_reason;
    logic        zero_interval;

    steer_scoreboard sb;
    int          send_idle_pct, stall_pct;
    bit          hold_off;
    logic [31:0] tick_base;

    line_follow_pd_steering_unit dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #50ms;
        $display("testbench failed");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(left_drive, right_drive, motor_scale, stop_reason,
                            zero_interval);
        if (rst_n && in_valid && !in_stall)
            sb.note_frame('{raw_left_inner, raw_left_mid, raw_left_outer,
                            raw_right_inner, raw_right_mid, raw_right_outer},
                          tick_now, line_count);
    end

    always @(posedge clk)
    begin
        if (hold_off)
            out_stall <= 1'b1;
        else
            out_stall <= ($urandom_range(99) < stall_pct);
    end

    task automatic write_cfg(logic [2:0] idx, logic [63:0] v);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        @(posedge clk);
        sb.write_reg(idx, v);
        cfg_we <= 1'b0;
    endtask

    task automatic send_frame(logic [15:0] r[6], logic [31:0] t, logic [7:0] lc);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        raw_left_inner <= r[0]; raw_left_mid <= r[1]; raw_left_outer <= r[2];
        raw_right_inner <= r[3]; raw_right_mid <= r[4]; raw_right_outer <= r[5];
        tick_now <= t; line_count <= lc;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        in_valid <= 1'b0;
        while (sb.exp_left.size() != 0 && guard < 200000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (300) @(posedge clk);
    endtask

    function automatic logic [15:0] rand_raw();
        case ($urandom_range(5))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'($urandom_range(2000));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic random_frames(int count);
        logic [15:0] r[6];
        logic [7:0]  lc;
        for (int k = 0; k < count; k++)
        begin
            for (int i = 0; i < 6; i++) r[i] = rand_raw();
            if ($urandom_range(9) == 0)
                for (int i = 0; i < 6; i++) r[i] = ((i == 1 || i == 4) &&
                    $urandom_range(1)) ? rand_raw() : 16'd0;
            case ($urandom_range(9))
                0: lc = 8'($urandom);
                1: lc = 8'd2;
                default: lc = 8'($urandom_range(1));
            endcase
            case ($urandom_range(9))
                0: tick_base = tick_base;
                1: tick_base = $urandom;
                2: tick_base = tick_base - $urandom_range(100);
                default: tick_base = tick_base + $urandom_range(20);
            endcase
            send_frame(r, tick_base, lc);
        end
    endtask

    task automatic directed_frames();
        logic [15:0] z[6], w[6];
        z = '{default: 16'd0};
        w = '{default: 16'hFFFF};
        send_frame(w, 32'd5, 8'd2);
        send_frame(w, 32'd5, 8'd255);
        send_frame(z, 32'd6, 8'd0);
        send_frame('{16'd0, 16'hFFFF, 16'd0, 16'd0, 16'd0, 16'd0}, 32'd7, 8'd1);
        send_frame('{16'd0, 16'd0, 16'd0, 16'd0, 16'h8000, 16'd0}, 32'd9, 8'd0);
        send_frame('{16'hFFFF, 16'd0, 16'hFFFF, 16'd0, 16'd0, 16'd0}, 32'd9, 8'd0);
        send_frame('{16'd0, 16'd0, 16'd0, 16'hFFFF, 16'd0, 16'hFFFF}, 32'd3, 8'd0);
        send_frame(w, 32'hFFFF_FFFF, 8'd1);
        send_frame('{16'h1234, 16'h5555, 16'hAAAA, 16'h00FF, 16'hFF00, 16'h0F0F},
                   32'd0, 8'd0);
        send_frame(w, 32'd0, 8'd1);
    endtask

    initial
    begin
        sb = new();
        rst_n = 1'b0;
        cfg_we = 1'b0; cfg_index = 3'd0; cfg_data = 64'd0;
        in_valid = 1'b0; out_stall = 1'b0;
        raw_left_inner = '0; raw_left_mid = '0; raw_left_outer = '0;
        raw_right_inner = '0; raw_right_mid = '0; raw_right_outer = '0;
        tick_now = '0; line_count = '0;
        send_idle_pct = 0; stall_pct = 0; hold_off = 1'b0;
        tick_base = 32'd100;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_frames();
        drain();

        write_cfg(lfps_pkg::REG_DERIV_GAIN, 64'h0002_8000);
        write_cfg(lfps_pkg::REG_PROP_GAIN, 64'h00_4000);
        write_cfg(lfps_pkg::REG_CAL_MIN_A, 64'h0100_0200_0300_0400);
        write_cfg(lfps_pkg::REG_CAL_MAX_A, 64'hF000_0200_E000_0300);
        write_cfg(lfps_pkg::REG_CAL_MIN_B, 64'h0000_0500_0600);
        write_cfg(lfps_pkg::REG_CAL_MAX_B, 64'hD000_C000);
        directed_frames();
        random_frames(200);
        drain();

        send_idle_pct = 80;
        write_cfg(lfps_pkg::REG_SPEED_SCALE, 64'hFFFF);
        write_cfg(lfps_pkg::REG_PROP_GAIN, 64'hFF_FFFF);
        write_cfg(lfps_pkg::REG_DERIV_GAIN, 64'hFFFF_FFFF);
        random_frames(200);
        drain();

        send_idle_pct = 0;
        stall_pct = 80;
        write_cfg(lfps_pkg::REG_SPEED_SCALE, 64'h0);
        write_cfg(lfps_pkg::REG_PROP_GAIN, 64'h0);
        write_cfg(lfps_pkg::REG_CAL_MIN_A, 64'h0);
        write_cfg(lfps_pkg::REG_CAL_MAX_A, 64'hFFFF_FFFF_FFFF_FFFF);
        write_cfg(lfps_pkg::REG_CAL_MIN_B, 64'h0);
        write_cfg(lfps_pkg::REG_CAL_MAX_B, 64'hFFFF_FFFF);
        random_frames(200);
        drain();

        send_idle_pct = 11;
        stall_pct = 11;
        write_cfg(lfps_pkg::REG_PROP_GAIN, 64'h03_0000);
        write_cfg(lfps_pkg::REG_DERIV_GAIN, 64'h0000_4000);
        write_cfg(lfps_pkg::REG_SPEED_SCALE, 64'h8000);
        fork
            begin
                hold_off = 1'b1;
                repeat (2000) @(posedge clk);
                hold_off = 1'b0;
            end
            random_frames(8);
        join
        random_frames(390);
        drain();

        if (sb.errors == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end
endmodule
